// ===== design/bsi_pkg.sv =====
// Shared widths, register indices and constants for the broadcast source index block.
package bsi_pkg;

   localparam int NUM_DIMS   = 4;
   localparam int SIZE_W     = 16;
   localparam int INDEX_W    = 32;
   localparam int CSR_ADDR_W = 3;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [SIZE_W-1:0]     size_type;
   typedef logic [INDEX_W-1:0]    index_type;

   localparam csr_addr_type CSR_OUT_D0 = csr_addr_type'(0);
   localparam csr_addr_type CSR_IN_D0  = csr_addr_type'(NUM_DIMS);

endpackage

// ===== design/bsi_if.sv =====
// Handshake channel interfaces for the request, response and register write ports.
interface bsi_req_if;
   import bsi_pkg::*;
   logic      valid;
   logic      ready;
   index_type flat_out_index;
   modport source (output valid, output flat_out_index, input ready);
   modport sink (input valid, input flat_out_index, output ready);
endinterface

interface bsi_rsp_if;
   import bsi_pkg::*;
   logic      valid;
   logic      ready;
   index_type source_index;
   logic      index_error;
   modport source (output valid, output source_index, output index_error, input ready);
   modport sink (input valid, input source_index, input index_error, output ready);
endinterface

interface bsi_csr_if;
   import bsi_pkg::*;
   logic         valid;
   logic         ready;
   csr_addr_type index;
   size_type     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/broadcast_source_index_core.sv =====
// Broadcast source index generator: pipelined mixed-radix split, clamp and recombine.
// The pipeline computes one restoring-division bit per stage for each dimension,
// then clamp, multiply and sum stages. Throughput is one beat per cycle; the whole
// pipeline holds when a finished result is not taken. Reset clears the valid bits and sets
// every size register to 1; the registered input strides are rebuilt after a register write.
module broadcast_source_index_core #(
   parameter int MAX_RANK = 4
) (
   input  logic clock,
   input  logic reset,
   bsi_req_if.sink   req_chan,
   bsi_rsp_if.source rsp_chan,
   bsi_csr_if.sink   csr_chan
);
   import bsi_pkg::*;

   localparam int DIV_BITS = INDEX_W;
   localparam int NST      = DIV_BITS * MAX_RANK;

   typedef logic [MAX_RANK-1:0][SIZE_W-1:0]  coord_vec_type;
   typedef logic [MAX_RANK-1:0][INDEX_W-1:0] stride_vec_type;

   size_type       out_sz_ff [NUM_DIMS];
   size_type       in_sz_ff  [NUM_DIMS];
   size_type       osz_eff   [MAX_RANK];
   size_type       isz_eff   [MAX_RANK];
   stride_vec_type istr_ff;
   logic           osz_zero;
   logic           adv;

   logic          vld_ff [1:NST];
   index_type     n_ff   [1:NST];
   size_type      r_ff   [1:NST];
   coord_vec_type c_ff   [1:NST];

   logic           cl_vld_ff;
   logic           cl_err_ff;
   coord_vec_type  cl_ff;
   logic           mul_vld_ff;
   logic           mul_err_ff;
   stride_vec_type prod_ff;
   logic           out_vld_ff;
   logic           out_err_ff;
   index_type      out_src_ff;
   index_type      sum_in;

   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_DIMS; k++) begin
            out_sz_ff[k] <= size_type'(1);
            in_sz_ff[k]  <= size_type'(1);
         end
      end else if (csr_chan.valid) begin
         if (csr_chan.index < CSR_IN_D0) begin
            out_sz_ff[csr_chan.index[1:0]] <= csr_chan.data;
         end else begin
            in_sz_ff[csr_chan.index[1:0]] <= csr_chan.data;
         end
      end
   end

   always_comb begin
      osz_zero = 1'b0;
      for (int j = 0; j < MAX_RANK; j++) begin
         osz_eff[j] = out_sz_ff[NUM_DIMS-1-j];
         isz_eff[j] = (in_sz_ff[NUM_DIMS-1-j] == '0) ? size_type'(1)
                                                     : in_sz_ff[NUM_DIMS-1-j];
         if (out_sz_ff[NUM_DIMS-1-j] == '0) begin
            osz_zero = 1'b1;
         end
      end
   end

   // Input strides, innermost first, built up one multiply per cycle.
   always_ff @(posedge clock) begin
      istr_ff[0] <= index_type'(1);
      for (int j = 1; j < MAX_RANK; j++) begin
         istr_ff[j] <= index_type'(istr_ff[j-1] * isz_eff[j-1]);
      end
   end

   for (genvar s = 0; s < NST; s++) begin : g_div
      localparam int J     = s / DIV_BITS;
      localparam bit FIRST = (s % DIV_BITS) == 0;
      localparam bit LAST  = (s % DIV_BITS) == DIV_BITS - 1;

      logic          vld_prev;
      index_type     n_prev;
      size_type      r_prev;
      coord_vec_type c_prev;
      logic [SIZE_W:0] t;
      logic [SIZE_W:0] diff;
      logic          ge;
      size_type      r_new;
      coord_vec_type c_new;

      if (s == 0) begin : g_head
         assign vld_prev = req_chan.valid;
         assign n_prev   = req_chan.flat_out_index;
         assign r_prev   = '0;
         assign c_prev   = '0;
      end else begin : g_body
         assign vld_prev = vld_ff[s];
         assign n_prev   = n_ff[s];
         assign r_prev   = FIRST ? size_type'(0) : r_ff[s];
         assign c_prev   = c_ff[s];
      end

      always_comb begin
         t     = {r_prev, n_prev[INDEX_W-1]};
         diff  = t - {1'b0, osz_eff[J]};
         ge    = t >= {1'b0, osz_eff[J]};
         r_new = ge ? diff[SIZE_W-1:0] : t[SIZE_W-1:0];
         c_new = c_prev;
         if (LAST) begin
            c_new[J] = r_new;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[s+1] <= {n_prev[INDEX_W-2:0], ge};
            r_ff[s+1] <= r_new;
            c_ff[s+1] <= c_new;
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MAX_RANK; j++) begin
         sum_in = sum_in + prod_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cl_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         cl_vld_ff  <= vld_ff[NST];
         mul_vld_ff <= cl_vld_ff;
         out_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cl_err_ff <= (n_ff[NST] != '0) || osz_zero;
         for (int j = 0; j < MAX_RANK; j++) begin
            cl_ff[j] <= (c_ff[NST][j] > isz_eff[j] - size_type'(1))
                        ? isz_eff[j] - size_type'(1) : c_ff[NST][j];
            prod_ff[j] <= index_type'(cl_ff[j] * istr_ff[j]);
         end
         mul_err_ff <= cl_err_ff;
         out_err_ff <= mul_err_ff;
         out_src_ff <= mul_err_ff ? index_type'(0) : sum_in;
      end
   end

   assign rsp_chan.valid        = out_vld_ff;
   assign rsp_chan.source_index = out_src_ff;
   assign rsp_chan.index_error  = out_err_ff;

endmodule

// ===== bench/bsi_index_checker.sv =====
// Scoreboard that predicts every source index from the observed register writes and checks it.
module bsi_index_checker (
   input  logic clock,
   input  logic reset,
   bsi_req_if   req,
   bsi_rsp_if   rsp,
   bsi_csr_if   csr,
   output int   failures,
   output int   outstanding
);
   import bsi_pkg::*;

   typedef struct packed {
      index_type source_index;
      logic      index_error;
   } src_beat_type;

   size_type     out_dim [NUM_DIMS];
   size_type     in_dim [NUM_DIMS];
   src_beat_type pending_sources [$];

   function automatic src_beat_type map_to_source(index_type flat);
      bit [63:0] ostride [NUM_DIMS];
      bit [63:0] istride [NUM_DIMS];
      bit [63:0] total, itotal, rem, coord, isz, src;
      src_beat_type r;
      total  = 64'd1;
      itotal = 64'd1;
      for (int k = NUM_DIMS - 1; k >= 0; k--) begin
         isz        = (in_dim[k] == 0) ? 64'd1 : 64'(in_dim[k]);
         ostride[k] = total;
         istride[k] = itotal;
         total      = total * 64'(out_dim[k]);
         itotal     = itotal * isz;
      end
      r.source_index = '0;
      r.index_error  = 1'b1;
      if (64'(flat) < total) begin
         rem = 64'(flat);
         src = 64'd0;
         for (int k = 0; k < NUM_DIMS; k++) begin
            isz   = (in_dim[k] == 0) ? 64'd1 : 64'(in_dim[k]);
            coord = rem / ostride[k];
            rem   = rem - coord * ostride[k];
            if (coord > isz - 64'd1) coord = isz - 64'd1;
            src   = src + coord * istride[k];
         end
         r.source_index = src[INDEX_W-1:0];
         r.index_error  = 1'b0;
      end
      return r;
   endfunction

   assign outstanding = pending_sources.size();

   always @(posedge clock) begin
      src_beat_type want;
      if (reset) begin
         for (int k = 0; k < NUM_DIMS; k++) begin
            out_dim[k] <= size_type'(1);
            in_dim[k]  <= size_type'(1);
         end
         failures <= 0;
         pending_sources.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index < CSR_IN_D0) out_dim[csr.index[1:0]] <= csr.data;
            else in_dim[csr.index[1:0]] <= csr.data;
         end
         if (req.valid && req.ready) pending_sources.push_back(map_to_source(req.flat_out_index));
         if (rsp.valid && rsp.ready) begin
            if (pending_sources.size() == 0) begin
               $display("%0t: unexpected beat source_index=%h index_error=%b",
                        $time, rsp.source_index, rsp.index_error);
               failures <= failures + 1;
            end else begin
               want = pending_sources.pop_front();
               if (want.source_index !== rsp.source_index
                   || want.index_error !== rsp.index_error) begin
                  $display("%0t: expected source_index=%h index_error=%b, got %h %b",
                           $time, want.source_index, want.index_error,
                           rsp.source_index, rsp.index_error);
                  failures <= failures + 1;
               end
            end
         end
      end
   end
endmodule

// ===== bench/testbench.sv =====
// Top level that drives the broadcast source index block and reports the verdict.
module testbench;
   import bsi_pkg::*;

   localparam int LATENCY = 32 * NUM_DIMS + 3;
   localparam int LIMIT   = 600000;

   logic clock = 0;
   logic reset = 1;
   int   failures, outstanding, cycles = 0;
   bit   steady = 0;
   bit [63:0] out_total;

   bsi_req_if req ();
   bsi_rsp_if rsp ();
   bsi_csr_if csr ();

   broadcast_source_index_core #(.MAX_RANK(NUM_DIMS)) dut (
      .clock(clock), .reset(reset), .req_chan(req), .rsp_chan(rsp), .csr_chan(csr));

   bsi_index_checker checker_i (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr),
      .failures(failures), .outstanding(outstanding));

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int stall;
      rsp.ready = 0;
      @(negedge reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   task automatic send_index(index_type flat);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req.valid          <= 1;
      req.flat_out_index <= flat;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain;
      req.valid <= 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic load_shape(size_type o0, o1, o2, o3, i0, i1, i2, i3);
      size_type vals [2*NUM_DIMS];
      vals = '{o0, o1, o2, o3, i0, i1, i2, i3};
      out_total = 64'(o0) * 64'(o1) * 64'(o2) * 64'(o3);
      for (int k = 0; k < 2 * NUM_DIMS; k++) begin
         csr.valid <= 1;
         csr.index <= (k < NUM_DIMS) ? CSR_OUT_D0 + csr_addr_type'(k)
                                     : CSR_IN_D0 + csr_addr_type'(k - NUM_DIMS);
         csr.data  <= vals[k];
         @(posedge clock);
         while (!csr.ready) @(posedge clock);
      end
      csr.valid <= 0;
      repeat (2 * NUM_DIMS) @(posedge clock);
   endtask

   task automatic edge_indices;
      send_index('0);
      send_index('1);
      if (out_total != 0) begin
         send_index(index_type'(out_total - 1));
         send_index(index_type'(out_total));
      end
   endtask

   function automatic size_type pick_in(size_type o);
      case ($urandom_range(0, 9))
         0, 1, 2: return 1;
         3:       return 0;
         4:       return size_type'($urandom_range(1, 12));
         default: return o;
      endcase
   endfunction

   task automatic random_phase(int count);
      size_type o [NUM_DIMS];
      for (int k = 0; k < NUM_DIMS; k++)
         o[k] = ($urandom_range(0, 9) == 0) ? size_type'($urandom_range(1, 400))
                                            : size_type'($urandom_range(1, 9));
      if ($urandom_range(0, 19) == 0) o[2'($urandom_range(0, 3))] = '0;
      load_shape(o[0], o[1], o[2], o[3], pick_in(o[0]), pick_in(o[1]),
                 pick_in(o[2]), pick_in(o[3]));
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < count; n++) begin
         if (out_total != 0 && $urandom_range(0, 9) < 8)
            send_index(index_type'({$urandom, $urandom} % out_total));
         else
            send_index($urandom);
      end
      drain();
      steady = 0;
   endtask

   initial begin
      req.valid = 0;
      req.flat_out_index = '0;
      csr.valid = 0;
      csr.index = '0;
      csr.data = '0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      out_total = 1;
      edge_indices();
      drain();
      load_shape(2, 3, 4, 5, 1, 3, 1, 5);
      edge_indices();
      send_index(37);
      drain();
      load_shape('1, '1, '1, '1, '1, '1, '1, '1);
      edge_indices();
      send_index(32'h8000_0000);
      drain();
      load_shape(3, 0, 4, 2, 3, 1, 4, 2);
      edge_indices();
      drain();
      load_shape(2, 6, 5, 7, 0, 2, 0, 3);
      edge_indices();
      send_index(200);
      drain();
      load_shape(1, 1, 1, 16'h00ff, 16'hffff, 16'h8000, 16'h1234, 1);
      edge_indices();
      drain();
      for (int p = 0; p < 12; p++) random_phase(150);
      repeat (LATENCY + 10) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
